>>> src/timed_event_slot_table_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the timed event slot table unit
// Shorthand for clocked assertions with synchronous reset masking.
// ---------------------------------------------------------------------------
`ifndef TIMED_EVENT_SLOT_TABLE_UNIT_MACROS_SVH
`define TIMED_EVENT_SLOT_TABLE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TEVST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TEVST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tevst_pkg.sv
// ---------------------------------------------------------------------------
// Timed event slot table package
// Sizes, operation and result codes, controller states and the command
// bundle sent to the slot occupancy tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package tevst_pkg;

   localparam int CAPACITY   = 32;
   localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int ID_W       = 32;
   localparam int TICK_W     = 32;
   localparam int WAIT_W     = 16;
   localparam int OUT_SLOT_W = 5;
   localparam int ENTRY_W    = ID_W + TICK_W;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_TICK   = 2'd1,
      OP_DELETE = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_ADDED     = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_EXPIRED   = 3'd2,
      KIND_DESTROYED = 3'd3,
      KIND_DELETED   = 3'd4,
      KIND_DONE      = 3'd5,
      KIND_REJECTED  = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_CHECK,
      ST_ADD_SEARCH,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH,
      ST_DELETE
   } state_type;

   typedef struct packed {
      logic              set_en;
      logic [SLOT_W-1:0] set_slot;
      logic              clr_en;
      logic [SLOT_W-1:0] clr_slot;
      logic              clr_all;
   } live_cmd_type;

   // Slot numbers are reported modulo two to the power of the result field's width.
   function automatic logic [OUT_SLOT_W-1:0] out_slot_of(input logic [SLOT_W-1:0] s);
      logic [63:0] w;
      w = 64'(s);
      return w[OUT_SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/tevst_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module tevst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/tevst_live.sv
// ---------------------------------------------------------------------------
// Slot occupancy tracker
// Holds one live bit per slot, the live count and the rotating free hint.
// ---------------------------------------------------------------------------
`default_nettype none

module tevst_live (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tevst_pkg::live_cmd_type        cmd,
   output logic      [tevst_pkg::CAPACITY-1:0] live,
   output logic      [tevst_pkg::CNT_W-1:0]    count,
   output logic      [tevst_pkg::SLOT_W-1:0]   hint
);
   import tevst_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

   logic [CAPACITY-1:0] live_ff, live_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]   hint_ff, hint_in;

   always_comb begin
      live_in  = live_ff;
      count_in = count_ff;
      hint_in  = hint_ff;
      if (cmd.clr_all) begin
         live_in  = '0;
         count_in = '0;
         hint_in  = '0;
      end else begin
         if (cmd.set_en && !live_ff[cmd.set_slot]) begin
            live_in[cmd.set_slot] = 1'b1;
            count_in = count_ff + CNT_W'(1);
            hint_in  = (cmd.set_slot == LAST_SLOT) ? '0 : cmd.set_slot + SLOT_W'(1);
         end
         // Freeing a slot below the hint pulls the hint back to it.
         if (cmd.clr_en && live_ff[cmd.clr_slot]) begin
            live_in[cmd.clr_slot] = 1'b0;
            count_in = count_ff - CNT_W'(1);
            if (cmd.clr_slot < hint_ff) begin
               hint_in = cmd.clr_slot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         count_ff <= '0;
         hint_ff  <= '0;
      end else begin
         live_ff  <= live_in;
         count_ff <= count_in;
         hint_ff  <= hint_in;
      end
   end

   assign live  = live_ff;
   assign count = count_ff;
   assign hint  = hint_ff;

endmodule

`default_nettype wire

>>> src/timed_event_slot_table_unit.sv
// Tick and flush hold busy while one slot entry is read per cycle from the entry RAM,
// then pass a drain and a finish state; on an empty table either goes straight to finish.
// Add ends in its check state when rejected or full, else it searches with one occupancy
// probe per cycle until a free slot is found or none is; delete has its own state.
// Each result is registered and appears in the cycle after it is decided; the next
// transfer can start when the final result appears. Synchronous reset empties the
// table through the live bits and clears the clock, count and hint, not the entry RAM.
// ---------------------------------------------------------------------------
// Timed event slot table unit
// Controller and datapath around one entry RAM holding the id and due time
// of each slot, with a live-bit tracker beside it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "timed_event_slot_table_unit_macros.svh"

module timed_event_slot_table_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_event_id,
   input  wire logic [15:0] req_wait_ticks,
   input  wire logic [15:0] req_advance_ticks,
   input  wire logic [4:0]  req_slot_index,
   output logic             rsp_valid,
   output logic      [2:0]  rsp_kind,
   output logic      [31:0] rsp_out_id,
   output logic      [4:0]  rsp_out_slot,
   output logic             rsp_last
);
   import tevst_pkg::*;

   localparam int                SUM_W     = SLOT_W + 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

   state_type          state_ff, state_in;
   op_type             op_ff;
   logic [ID_W-1:0]    id_ff;
   logic [WAIT_W-1:0]  wait_ff;
   logic [4:0]         sidx_ff;
   logic [TICK_W-1:0]  now_ff;
   logic [SLOT_W-1:0]  k_ff, k_in;
   logic               p_valid_ff, p_valid_in;
   logic [SLOT_W-1:0]  p_slot_ff, p_slot_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [OUT_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic               rsp_last_ff, rsp_last_in;

   live_cmd_type       cmd;
   logic [CAPACITY-1:0] live_vec;
   logic [CNT_W-1:0]   live_cnt;
   logic [SLOT_W-1:0]  free_hint;

   logic               wr_en, rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [SUM_W-1:0]   probe_sum;
   logic [SLOT_W-1:0]  probe_slot;
   logic [ID_W-1:0]    ent_id;
   logic [TICK_W-1:0]  ent_due, diff;
   logic               hit;
   logic               accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   tevst_live u_live (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .live  (live_vec),
      .count (live_cnt),
      .hint  (free_hint)
   );

   tevst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (probe_slot),
      .wr_data ({id_ff, now_ff + TICK_W'(wait_ff)}),
      .rd_en   (rd_en),
      .rd_addr (k_ff),
      .rd_data (rd_data)
   );

   // Free-slot search walks from the hint and wraps round the table.
   always_comb begin
      probe_sum = SUM_W'(free_hint) + SUM_W'(k_ff);
      if (probe_sum >= SUM_W'(CAPACITY)) begin
         probe_sum = probe_sum - SUM_W'(CAPACITY);
      end
      probe_slot = SLOT_W'(probe_sum);
   end

   // The entry read last cycle is judged now; only this slot is freed, so
   // reads of later slots never see a pending write.
   assign ent_id  = rd_data[ENTRY_W-1 -: ID_W];
   assign ent_due = rd_data[TICK_W-1:0];
   assign diff    = now_ff - ent_due;
   assign hit     = p_valid_ff && live_vec[p_slot_ff]
                    && ((op_ff == OP_FLUSH) || !diff[TICK_W-1]);

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      p_valid_in   = 1'b0;
      p_slot_in    = k_ff;
      cmd          = '0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_DONE;
      rsp_id_in    = '0;
      rsp_slot_in  = '0;
      rsp_last_in  = 1'b0;

      if (hit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = (op_ff == OP_FLUSH) ? KIND_DESTROYED : KIND_EXPIRED;
         rsp_id_in    = ent_id;
         rsp_slot_in  = out_slot_of(p_slot_ff);
         cmd.clr_en   = 1'b1;
         cmd.clr_slot = p_slot_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               k_in = '0;
               case (op_type'(req_op))
                  OP_ADD:    state_in = ST_ADD_CHECK;
                  OP_DELETE: state_in = ST_DELETE;
                  default:   state_in = (live_cnt != '0) ? ST_SCAN : ST_FINISH;
               endcase
            end
         end
         ST_ADD_CHECK: begin
            k_in = '0;
            if (id_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_REJECTED;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else if (live_cnt >= CNT_W'(CAPACITY)) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FULL;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_ADD_SEARCH;
            end
         end
         ST_ADD_SEARCH: begin
            if (!live_vec[probe_slot]) begin
               wr_en        = 1'b1;
               cmd.set_en   = 1'b1;
               cmd.set_slot = probe_slot;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ADDED;
               rsp_slot_in  = out_slot_of(probe_slot);
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else if (k_ff == LAST_SLOT) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FULL;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               k_in = k_ff + SLOT_W'(1);
            end
         end
         ST_SCAN: begin
            rd_en      = 1'b1;
            p_valid_in = 1'b1;
            p_slot_in  = k_ff;
            if (k_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + SLOT_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_DONE;
            rsp_last_in  = 1'b1;
            cmd.clr_all  = (op_ff == OP_FLUSH);
            state_in     = ST_IDLE;
         end
         ST_DELETE: begin
            if ({3'b000, sidx_ff} < 8'(CAPACITY)) begin
               cmd.clr_en   = 1'b1;
               cmd.clr_slot = SLOT_W'(sidx_ff);
            end
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_DELETED;
            rsp_slot_in  = sidx_ff;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && (op_type'(req_op) == OP_TICK)) begin
            now_ff <= now_ff + TICK_W'(req_advance_ticks);
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      p_slot_ff   <= p_slot_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
      if (accept) begin
         op_ff   <= op_type'(req_op);
         id_ff   <= req_event_id;
         wait_ff <= req_wait_ticks;
         sidx_ff <= req_slot_index;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_out_id   = rsp_id_ff;
   assign rsp_out_slot = rsp_slot_ff;
   assign rsp_last     = rsp_last_ff;

   `TEVST_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transfer did not raise busy")
   `TEVST_ASSERT_NOW(a_count_live, 1'b1, $countones(live_vec) == int'(live_cnt),
                     "live count mismatch")
   `TEVST_ASSERT_NOW(a_mid_kind, rsp_valid && !rsp_last,
                     rsp_kind == KIND_EXPIRED || rsp_kind == KIND_DESTROYED,
                     "bad non-final kind")
   `TEVST_ASSERT_NEXT(a_last_gap, rsp_valid && rsp_last, !rsp_valid,
                      "result right after final result")

endmodule

`default_nettype wire

>>> tb/slot_table_checker.sv
// ---------------------------------------------------------------------------
// Timed event slot table checker
// Watches the command and result channels of the slot table unit, keeps its
// own copy of the slot table, works out the results of every accepted
// command and compares each result, field by field, in arrival order.
// ---------------------------------------------------------------------------
module slot_table_checker
   import tevst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_event_id,
   input  logic [15:0] req_wait_ticks,
   input  logic [15:0] req_advance_ticks,
   input  logic [4:0]  req_slot_index,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_kind,
   input  logic [31:0] rsp_out_id,
   input  logic [4:0]  rsp_out_slot,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          reports_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      kind_type    kind;
      logic [31:0] id;
      logic [4:0]  slot;
      logic        last;
   } slot_report_type;

   // Mirror of the slot table.
   logic [31:0] tbl_id [CAPACITY];
   logic [31:0] tbl_due [CAPACITY];
   logic [31:0] tbl_now;
   int          tbl_live;
   int          tbl_hint;

   slot_report_type awaited_reports[$];

   initial begin
      mismatch_count  = 0;
      reports_pending = 0;
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   function automatic void queue_report(input kind_type kind, input logic [31:0] id,
                                        input int slot, input logic last);
      slot_report_type r;
      r.kind = kind;
      r.id   = id;
      r.slot = 5'(slot);
      r.last = last;
      awaited_reports.push_back(r);
   endfunction

   function automatic void release_slot(input int s);
      if (tbl_id[s] != '0) begin
         tbl_id[s] = '0;
         if (tbl_live > 0) begin
            tbl_live--;
         end
         if (s < tbl_hint) begin
            tbl_hint = s;
         end
      end
   endfunction

   function automatic void run_table_op(input op_type op, input logic [31:0] id,
                                        input logic [15:0] wt, input logic [15:0] adv,
                                        input logic [4:0] sidx);
      int          s;
      int          k;
      bit          placed;
      logic [31:0] lag;
      case (op)
         OP_ADD: begin
            if (id == '0) begin
               queue_report(KIND_REJECTED, '0, 0, 1'b1);
            end else if (tbl_live >= CAPACITY || tbl_hint >= CAPACITY) begin
               queue_report(KIND_FULL, '0, 0, 1'b1);
            end else begin
               placed = 1'b0;
               for (k = 0; k < CAPACITY && !placed; k++) begin
                  s = (tbl_hint + k) % CAPACITY;
                  if (tbl_id[s] == '0) begin
                     tbl_id[s]  = id;
                     tbl_due[s] = tbl_now + 32'(wt);
                     tbl_live++;
                     tbl_hint = (s + 1 >= CAPACITY) ? 0 : s + 1;
                     queue_report(KIND_ADDED, '0, s, 1'b1);
                     placed = 1'b1;
                  end
               end
               if (!placed) begin
                  queue_report(KIND_FULL, '0, 0, 1'b1);
               end
            end
         end
         OP_TICK: begin
            tbl_now = tbl_now + 32'(adv);
            if (tbl_live != 0) begin
               for (k = 0; k < CAPACITY; k++) begin
                  if (tbl_id[k] != '0) begin
                     // Due when the wrapped difference is not negative.
                     lag = tbl_now - tbl_due[k];
                     if (!lag[31]) begin
                        queue_report(KIND_EXPIRED, tbl_id[k], k, 1'b0);
                        release_slot(k);
                     end
                  end
               end
            end
            queue_report(KIND_DONE, '0, 0, 1'b1);
         end
         OP_DELETE: begin
            if (int'(sidx) < CAPACITY) begin
               release_slot(int'(sidx));
            end
            queue_report(KIND_DELETED, '0, int'(sidx), 1'b1);
         end
         default: begin
            for (k = 0; k < CAPACITY; k++) begin
               if (tbl_id[k] != '0) begin
                  queue_report(KIND_DESTROYED, tbl_id[k], k, 1'b0);
                  tbl_id[k] = '0;
               end
            end
            tbl_live = 0;
            tbl_hint = 0;
            queue_report(KIND_DONE, '0, 0, 1'b1);
         end
      endcase
   endfunction

   task automatic check_report();
      slot_report_type exp;
      if (awaited_reports.size() == 0) begin
         flag_mismatch($sformatf("result with none expected: kind %0d id %h slot %0d last %b",
                                 rsp_kind, rsp_out_id, rsp_out_slot, rsp_last));
         return;
      end
      exp = awaited_reports.pop_front();
      if (rsp_kind !== exp.kind) begin
         flag_mismatch($sformatf("kind %0d, expected %s", rsp_kind, exp.kind.name()));
      end
      if (rsp_out_id !== exp.id) begin
         flag_mismatch($sformatf("out_id %h, expected %h (%s)", rsp_out_id, exp.id,
                                 exp.kind.name()));
      end
      if (rsp_out_slot !== exp.slot) begin
         flag_mismatch($sformatf("out_slot %0d, expected %0d (%s)", rsp_out_slot, exp.slot,
                                 exp.kind.name()));
      end
      if (rsp_last !== exp.last) begin
         flag_mismatch($sformatf("last %b, expected %b (%s)", rsp_last, exp.last,
                                 exp.kind.name()));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CAPACITY; k++) begin
            tbl_id[k]  = '0;
            tbl_due[k] = '0;
         end
         tbl_now  = '0;
         tbl_live = 0;
         tbl_hint = 0;
         awaited_reports.delete();
      end else begin
         // A result always trails its own command, so checking it first is safe.
         if (rsp_valid) begin
            check_report();
         end
         if (start && !busy) begin
            run_table_op(op_type'(req_op), req_event_id, req_wait_ticks, req_advance_ticks,
                         req_slot_index);
         end
      end
      reports_pending = awaited_reports.size();
   end

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// Timed event slot table unit testbench
// Drives directed and random add, tick, delete and flush commands with
// random sender gaps; the checker beside the unit predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tevst_pkg::*;

   localparam int RANDOM_ITEMS = 160;
   localparam int TAIL_CYCLES  = 40;
   localparam int LIMIT_CYCLES = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = '0;
   logic [31:0] req_event_id = '0;
   logic [15:0] req_wait_ticks = '0;
   logic [15:0] req_advance_ticks = '0;
   logic [4:0]  req_slot_index = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_out_id;
   logic [4:0]  rsp_out_slot;
   logic        rsp_last;

   int          mismatches;
   int          pending;
   int          cycle_cnt = 0;
   int          sent_cnt = 0;
   int          rand_base;
   int          pick;
   bit          gaps_on = 1'b1;
   bit          table_filled = 1'b0;
   op_type      rand_op;
   logic [31:0] rand_id;

   timed_event_slot_table_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_event_id      (req_event_id),
      .req_wait_ticks    (req_wait_ticks),
      .req_advance_ticks (req_advance_ticks),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_slot      (rsp_out_slot),
      .rsp_last          (rsp_last)
   );

   slot_table_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_event_id      (req_event_id),
      .req_wait_ticks    (req_wait_ticks),
      .req_advance_ticks (req_advance_ticks),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_slot      (rsp_out_slot),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatches),
      .reports_pending   (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [15:0] rand_wait();
      return ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 300))
                                         : 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] rand_advance();
      return ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 120))
                                         : 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [31:0] nonzero_id();
      logic [31:0] v;
      v = $urandom;
      return (v == '0) ? 32'd1 : v;
   endfunction

   // Holds the command until the unit takes it, then may idle for a burst.
   task automatic issue_cmd(input op_type op, input logic [31:0] id, input logic [15:0] wt,
                            input logic [15:0] adv, input logic [4:0] sidx);
      start             <= 1'b1;
      req_op            <= op;
      req_event_id      <= id;
      req_wait_ticks    <= wt;
      req_advance_ticks <= adv;
      req_slot_index    <= sidx;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_cnt++;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty ticks, rejection, extreme waits, zero-lag expiry,
      // deletes of free and live slots, flushes with and without entries.
      issue_cmd(OP_TICK,   32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 5'd31);
      issue_cmd(OP_TICK,   32'h0,         16'h0,    16'hFFFF, 5'd0);
      issue_cmd(OP_ADD,    32'h0,         16'd5,    16'hFFFF, 5'd31);
      issue_cmd(OP_ADD,    32'hFFFF_FFFF, 16'h0000, 16'h0,    5'd0);
      issue_cmd(OP_ADD,    32'h0000_0001, 16'hFFFF, 16'h0,    5'd0);
      issue_cmd(OP_ADD,    32'h8000_0000, 16'h0001, 16'h0,    5'd0);
      issue_cmd(OP_ADD,    32'h5A5A_5A5A, 16'h8000, 16'h0,    5'd0);
      issue_cmd(OP_TICK,   32'h0,         16'h0,    16'h0000, 5'd0);
      issue_cmd(OP_DELETE, 32'h0,         16'h0,    16'h0,    5'd31);
      issue_cmd(OP_DELETE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 5'd1);
      issue_cmd(OP_ADD,    32'h1234_5678, 16'h0002, 16'h0,    5'd0);
      issue_cmd(OP_TICK,   32'h0,         16'h0,    16'h0001, 5'd0);
      issue_cmd(OP_DELETE, 32'h0,         16'h0,    16'h0,    5'd0);
      issue_cmd(OP_FLUSH,  32'h0,         16'h0,    16'h0,    5'd0);
      issue_cmd(OP_FLUSH,  32'hA5A5_A5A5, 16'h5555, 16'hAAAA, 5'd21);
      issue_cmd(OP_TICK,   32'h0,         16'h0,    16'h7FFF, 5'd10);
      issue_cmd(OP_ADD,    32'hFFFF_FFFE, 16'h7FFF, 16'h0,    5'd0);
      issue_cmd(OP_ADD,    32'h0000_0002, 16'hFFFF, 16'h0,    5'd0);
      issue_cmd(OP_TICK,   32'h0,         16'h0,    16'hFFFF, 5'd0);
      issue_cmd(OP_DELETE, 32'h0,         16'h0,    16'h0,    5'd16);

      rand_base = sent_cnt;
      while (sent_cnt < rand_base + RANDOM_ITEMS) begin
         // Stretches of twenty commands without gaps; none near the end.
         gaps_on = (sent_cnt < rand_base + RANDOM_ITEMS - 30) && ((sent_cnt / 20) % 3 != 2);
         pick = $urandom_range(0, 99);
         if ((!table_filled && sent_cnt > rand_base + 60) || pick < 2) begin
            // Overfill the table, free a few slots, refill them across the
            // wrap of the search and expire everything in one scan.
            table_filled = 1'b1;
            repeat (CAPACITY + 2) begin
               issue_cmd(OP_ADD, nonzero_id(), rand_wait(), rand_advance(), 5'($urandom));
            end
            repeat (3) begin
               issue_cmd(OP_DELETE, $urandom, rand_wait(), rand_advance(),
                         5'($urandom_range(0, 31)));
            end
            repeat (2) begin
               issue_cmd(OP_ADD, nonzero_id(), rand_wait(), rand_advance(), 5'($urandom));
            end
            issue_cmd(OP_TICK, $urandom, rand_wait(), 16'hFFFF, 5'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               rand_op = OP_ADD;
            end else if (pick < 70) begin
               rand_op = OP_TICK;
            end else if (pick < 96) begin
               rand_op = OP_DELETE;
            end else begin
               rand_op = OP_FLUSH;
            end
            rand_id = ($urandom_range(0, 15) == 0) ? 32'h0 : 32'($urandom);
            issue_cmd(rand_op, rand_id, rand_wait(), rand_advance(),
                      5'($urandom_range(0, 31)));
         end
      end
      start <= 1'b0;

      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
